// ===== sv/xor_framed_packet_receiver_core_assert.svh =====
// Assertion macros for the packet receiver core.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef XOR_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH
`define XOR_FRAMED_PACKET_RECEIVER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define XFPR_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("xfpr assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define XFPR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("xfpr assertion failed");

`endif

// ===== sv/xfpr_pkg.sv =====
package xfpr_pkg;

	// Frame header byte
	localparam logic [7:0] HDR_BYTE = 8'h06;

	// Number of per-type size registers
	localparam int SIZE_REGS = 4;

	// Configuration register indexes
	localparam logic [2:0] REG_NUM_TYPES  = 3'd0;
	localparam logic [2:0] REG_SIZE_TYPE0 = 3'd1;
	localparam logic [2:0] REG_SIZE_TYPE1 = 3'd2;
	localparam logic [2:0] REG_SIZE_TYPE2 = 3'd3;
	localparam logic [2:0] REG_SIZE_TYPE3 = 3'd4;

	// Configuration as seen by the frame engine
	typedef struct packed {
		logic [2:0]                  num_types;
		logic [SIZE_REGS-1:0][5:0]   size_reg;
	} cfg_t;

	// One result transaction
	typedef struct packed {
		logic [1:0] pkt_type;
		logic [4:0] byte_index;
		logic [7:0] data_byte;
		logic       last;
		logic       frame_status;
	} result_t;

	// Status from the frame engine
	typedef struct packed {
		logic burst_busy;
		logic hunting;
	} stat_t;

endpackage

// ===== sv/xor_framed_packet_receiver_core.sv =====
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-------------------------------------------
// input    | in_valid / in_stall        | rx_byte
// output   | out_valid / out_stall      | pkt_type, byte_index, data_byte, last,
//          |                            | frame_status
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// Header, type, length and payload bytes are taken at one per cycle unless in_stall is high.
// On a good checksum the input stalls while the payload store is swept, one read
// per cycle through its single read port while the output is not stalled.
// A bad checksum posts one error result; the checksum byte stalls until the output register is free.
// Reset clears the parser and output control; the payload store is not cleared.
// cfg_ready is always high.
`include "xor_framed_packet_receiver_core_assert.svh"

module xor_framed_packet_receiver_core #(
	parameter int NUM_TYPES   = 4,
	parameter int MAX_PAYLOAD = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] pkt_type,
	output logic [4:0] byte_index,
	output logic [7:0] data_byte,
	output logic       last,
	output logic       frame_status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [5:0] cfg_data
);

	import xfpr_pkg::*;

	localparam int PAYLOAD_LIMIT = (MAX_PAYLOAD < 32) ? MAX_PAYLOAD : 32;
	localparam int AW            = (PAYLOAD_LIMIT > 1) ? $clog2(PAYLOAD_LIMIT) : 1;

	logic [2:0]  num_types_q;
	logic [5:0]  size_q [SIZE_REGS];
	cfg_t        cfg;
	result_t     res;
	stat_t       stat;
	logic        mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]  mem_wdata;
	logic        mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]  mem_rdata;
	logic        cfg_acc;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_types_q <= 3'd4;
			size_q[0]   <= 6'd1;
			size_q[1]   <= 6'd1;
			size_q[2]   <= 6'd1;
			size_q[3]   <= 6'd1;
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_NUM_TYPES:  num_types_q <= cfg_data[2:0];
				REG_SIZE_TYPE0: size_q[0]   <= cfg_data;
				REG_SIZE_TYPE1: size_q[1]   <= cfg_data;
				REG_SIZE_TYPE2: size_q[2]   <= cfg_data;
				REG_SIZE_TYPE3: size_q[3]   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg.num_types   = num_types_q;
	assign cfg.size_reg[0] = size_q[0];
	assign cfg.size_reg[1] = size_q[1];
	assign cfg.size_reg[2] = size_q[2];
	assign cfg.size_reg[3] = size_q[3];

	xfpr_frame #(
		.NUM_TYPES     (NUM_TYPES),
		.PAYLOAD_LIMIT (PAYLOAD_LIMIT),
		.AW            (AW)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.stat      (stat)
	);

	xfpr_store #(
		.DEPTH (PAYLOAD_LIMIT),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign pkt_type     = res.pkt_type;
	assign byte_index   = res.byte_index;
	assign data_byte    = res.data_byte;
	assign last         = res.last;
	assign frame_status = res.frame_status;

	// Store sweep must keep new bytes out
	`XFPR_ASSERT_SAME(a_burst_stalls_input, stat.burst_busy, in_stall)
	// An error result is a single closing transaction with empty data
	`XFPR_ASSERT_SAME(a_error_shape, out_valid && frame_status,
		last && byte_index == 5'd0 && data_byte == 8'd0)
	// A type count write lands in the register
	`XFPR_ASSERT_NEXT(a_cfg_num_types, cfg_acc && cfg_index == REG_NUM_TYPES,
		num_types_q == $past(cfg_data[2:0]))

endmodule

// ===== sv/xfpr_store.sv =====
module xfpr_store #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	// Write payload byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/xfpr_frame.sv =====
module xfpr_frame #(
	parameter int NUM_TYPES     = 4,
	parameter int PAYLOAD_LIMIT = 32,
	parameter int AW            = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  xfpr_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       rx_byte,
	output logic             out_valid,
	input  logic             out_stall,
	output xfpr_pkg::result_t res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output logic [7:0]       mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  logic [7:0]       mem_rdata,
	output xfpr_pkg::stat_t  stat
);

	import xfpr_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LEN,
		PH_DATA,
		PH_CSUM
	} phase_t;

	phase_t      phase_q;
	logic [1:0]  type_q;
	logic [5:0]  exp_len_q;
	logic [5:0]  cnt_q;
	logic [7:0]  xor_q;
	logic        burst_q;
	logic [5:0]  rd_idx_q;
	logic        pend_s1;
	logic [4:0]  pend_idx_s1;
	logic        pend_last_s1;
	logic        out_valid_q;
	result_t     res_q;

	logic        in_acc;
	logic        slot_free;
	logic        advance;
	logic        issue;
	logic        rd_last;
	logic [5:0]  rd_idx_nxt;
	logic [5:0]  cnt_nxt;
	logic [2:0]  type_lim;
	logic        type_ok;
	logic        len_ok;

	// Stall input during a payload burst and while an error result cannot be posted
	assign in_stall  = burst_q || pend_s1 || (phase_q == PH_CSUM && out_valid_q);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;
	assign advance   = pend_s1 && slot_free;
	assign issue     = burst_q && (!pend_s1 || slot_free);

	assign rd_idx_nxt = rd_idx_q + 6'd1;
	assign rd_last    = (rd_idx_nxt == exp_len_q);
	assign cnt_nxt    = cnt_q + 6'd1;

	// Clamp the accepted type count to the size registers and the build limit
	always_comb begin
		type_lim = (cfg.num_types > 3'(SIZE_REGS)) ? 3'(SIZE_REGS) : cfg.num_types;
		if (NUM_TYPES < SIZE_REGS && type_lim > 3'(NUM_TYPES)) begin
			type_lim = 3'(NUM_TYPES);
		end
	end

	assign type_ok = rx_byte < {5'b0, type_lim};
	assign len_ok  = (rx_byte == {2'b0, cfg.size_reg[type_q]}) && (rx_byte != 8'd0) &&
		(rx_byte <= 8'(PAYLOAD_LIMIT));

	// Store payload bytes; reads happen only while input is stalled
	assign mem_we    = in_acc && (phase_q == PH_DATA) && (cnt_q < 6'(PAYLOAD_LIMIT));
	assign mem_waddr = cnt_q[AW-1:0];
	assign mem_wdata = rx_byte;
	assign mem_re    = issue;
	assign mem_raddr = rd_idx_q[AW-1:0];

	// Parse bytes, sweep the store on a good checksum, post results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			type_q       <= 2'd0;
			exp_len_q    <= 6'd0;
			cnt_q        <= 6'd0;
			xor_q        <= 8'd0;
			burst_q      <= 1'b0;
			rd_idx_q     <= 6'd0;
			pend_s1      <= 1'b0;
			pend_idx_s1  <= 5'd0;
			pend_last_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
			res_q        <= '0;
		end else begin
			// Move read data into the output register, or drop a taken result
			if (advance) begin
				out_valid_q        <= 1'b1;
				res_q.pkt_type     <= type_q;
				res_q.byte_index   <= pend_idx_s1;
				res_q.data_byte    <= mem_rdata;
				res_q.last         <= pend_last_s1;
				res_q.frame_status <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// Issue the next store read
			if (issue) begin
				pend_s1      <= 1'b1;
				pend_idx_s1  <= rd_idx_q[4:0];
				pend_last_s1 <= rd_last;
				rd_idx_q     <= rd_idx_nxt;
				if (rd_last) begin
					burst_q <= 1'b0;
				end
			end else if (advance) begin
				pend_s1 <= 1'b0;
			end

			// Advance the frame parser
			if (in_acc) begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == HDR_BYTE) begin
							phase_q <= PH_TYPE;
						end
					end
					PH_TYPE: begin
						if (type_ok) begin
							type_q  <= rx_byte[1:0];
							phase_q <= PH_LEN;
						end else begin
							phase_q <= PH_HUNT;
						end
					end
					PH_LEN: begin
						if (len_ok) begin
							exp_len_q <= rx_byte[5:0];
							xor_q     <= rx_byte;
							cnt_q     <= 6'd0;
							phase_q   <= PH_DATA;
						end else begin
							exp_len_q <= 6'd0;
							phase_q   <= PH_HUNT;
						end
					end
					PH_DATA: begin
						xor_q <= xor_q ^ rx_byte;
						cnt_q <= cnt_nxt;
						if (cnt_nxt >= exp_len_q) begin
							phase_q <= PH_CSUM;
						end
					end
					PH_CSUM: begin
						if (rx_byte == xor_q) begin
							burst_q  <= 1'b1;
							rd_idx_q <= 6'd0;
						end else begin
							out_valid_q        <= 1'b1;
							res_q.pkt_type     <= type_q;
							res_q.byte_index   <= 5'd0;
							res_q.data_byte    <= 8'd0;
							res_q.last         <= 1'b1;
							res_q.frame_status <= 1'b1;
						end
						cnt_q   <= 6'd0;
						phase_q <= PH_HUNT;
					end
					default: begin
						phase_q <= PH_HUNT;
					end
				endcase
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign res             = res_q;
	assign stat.burst_busy = burst_q || pend_s1;
	assign stat.hunting    = (phase_q == PH_HUNT);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import xfpr_pkg::*;

	localparam int N_TYPES     = 4;
	localparam int MAX_LEN     = 32;
	localparam int PAYLOAD_MAX = (MAX_LEN < 32) ? MAX_LEN : 32;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 150;

	// Register write order: position i of this list is register index i
	localparam logic [2:0] REG_ORDER [5] = '{REG_NUM_TYPES, REG_SIZE_TYPE0, REG_SIZE_TYPE1,
		REG_SIZE_TYPE2, REG_SIZE_TYPE3};

	// One register setting per random phase; upper bits of the type count are don't-care
	localparam logic [5:0] REG_PLAN [6][5] = '{
		'{6'd4,  6'd1, 6'd32, 6'd3,  6'd2},
		'{6'h38, 6'd5, 6'd5,  6'd5,  6'd5},
		'{6'd7,  6'd0, 6'd33, 6'd63, 6'd5},
		'{6'd2,  6'd4, 6'd1,  6'd2,  6'd3},
		'{6'd3,  6'd2, 6'd7,  6'd1,  6'd9},
		'{6'd5,  6'd6, 6'd8,  6'd31, 6'd1}};
	localparam int PHASE_BYTES [6] = '{30, 8, 12, 12, 10, 12};

	// Opening sequence under reset settings: noise at both byte extremes, a good type 3
	// frame, a bad checksum on type 0, a rejected type, a header byte used as a type,
	// a length mismatch on type 1 and a good type 2 frame
	localparam logic [7:0] OPENING [24] = '{
		8'h00, 8'hFF,
		8'h06, 8'h03, 8'h01, 8'hFF, 8'hFE,
		8'h06, 8'h00, 8'h01, 8'h00, 8'h00,
		8'h06, 8'h04,
		8'h06, 8'h06, 8'h06, 8'h01, 8'h02,
		8'h06, 8'h02, 8'h01, 8'h55, 8'h54};

	typedef enum logic [2:0] {HUNT, GET_TYPE, GET_LEN, GET_DATA, GET_SUM} parse_phase_t;

	// Tracks the deframer state and queues the payload deliveries it predicts
	class frame_checker;
		logic [2:0]   num_types;
		logic [5:0]   size_of [SIZE_REGS];
		parse_phase_t phase;
		logic [1:0]   cur_type;
		logic [5:0]   frame_len;
		logic [5:0]   count;
		logic [7:0]   sum;
		logic [7:0]   held [PAYLOAD_MAX];
		result_t      due_results [$];
		int           errors;

		function new();
			num_types = 3'd4;
			foreach (size_of[i]) size_of[i] = 6'd1;
			phase     = HUNT;
			cur_type  = '0;
			frame_len = '0;
			count     = '0;
			sum       = '0;
			errors    = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [5:0] val);
			case (idx)
				REG_NUM_TYPES:  num_types  = val[2:0];
				REG_SIZE_TYPE0: size_of[0] = val;
				REG_SIZE_TYPE1: size_of[1] = val;
				REG_SIZE_TYPE2: size_of[2] = val;
				REG_SIZE_TYPE3: size_of[3] = val;
				default: ;
			endcase
		endfunction

		// Number of type codes currently accepted
		function int type_limit();
			int lim;
			lim = num_types;
			if (lim > SIZE_REGS) lim = SIZE_REGS;
			if (lim > N_TYPES) lim = N_TYPES;
			return lim;
		endfunction

		// Advance the parser by one accepted byte
		function void take_rx_byte(logic [7:0] b);
			result_t r;
			case (phase)
				HUNT: begin
					if (b == HDR_BYTE) phase = GET_TYPE;
				end
				GET_TYPE: begin
					if (b < type_limit()) begin
						cur_type = b[1:0];
						phase    = GET_LEN;
					end else begin
						phase = HUNT;
					end
				end
				GET_LEN: begin
					if (b == {2'b00, size_of[cur_type]} && b >= 1 && b <= PAYLOAD_MAX) begin
						frame_len = b[5:0];
						sum       = b;
						count     = '0;
						phase     = GET_DATA;
					end else begin
						frame_len = '0;
						phase     = HUNT;
					end
				end
				GET_DATA: begin
					if (count < PAYLOAD_MAX) held[count] = b;
					sum   = sum ^ b;
					count = count + 6'd1;
					if (count >= frame_len) phase = GET_SUM;
				end
				GET_SUM: begin
					if (b == sum) begin
						for (int i = 0; i < frame_len; i++) begin
							r.pkt_type     = cur_type;
							r.byte_index   = i[4:0];
							r.data_byte    = held[i];
							r.last         = (i + 1 == frame_len);
							r.frame_status = 1'b0;
							due_results.push_back(r);
						end
					end else begin
						// Discard the frame and post a single error transaction
						r.pkt_type     = cur_type;
						r.byte_index   = '0;
						r.data_byte    = '0;
						r.last         = 1'b1;
						r.frame_status = 1'b1;
						due_results.push_back(r);
					end
					frame_len = '0;
					count     = '0;
					phase     = HUNT;
				end
				default: phase = HUNT;
			endcase
		endfunction

		function void compare_field(string field, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", field, want, got);
				errors++;
			end
		endfunction

		// Match one output transaction against the oldest prediction
		function void check_delivery(result_t got);
			result_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: pkt_type %0d byte_index %0d data_byte %0d",
					got.pkt_type, got.byte_index, got.data_byte);
				errors++;
				return;
			end
			want = due_results.pop_front();
			compare_field("pkt_type", want.pkt_type, got.pkt_type);
			compare_field("byte_index", want.byte_index, got.byte_index);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("last", want.last, got.last);
			compare_field("frame_status", want.frame_status, got.frame_status);
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] pkt_type;
	logic [4:0] byte_index;
	logic [7:0] data_byte;
	logic       last;
	logic       frame_status;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [5:0] cfg_data;

	frame_checker book;
	int tx_calm;
	int rx_calm;
	int results_seen;

	xor_framed_packet_receiver_core #(
		.NUM_TYPES  (N_TYPES),
		.MAX_PAYLOAD(MAX_LEN)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.pkt_type    (pkt_type),
		.byte_index  (byte_index),
		.data_byte   (data_byte),
		.last        (last),
		.frame_status(frame_status),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Draw a random wait, with occasional stretches of no waiting
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 30);
		return $urandom_range(0, 6);
	endfunction

	// Offer one byte and hold it until the transaction completes
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		book.take_rx_byte(b);
	endtask

	// Write every register back to back from one row of the plan
	task automatic program_regs(input int row);
		for (int i = 0; i < 5; i++) begin
			@(negedge clk);
			cfg_valid <= 1'b1;
			cfg_index <= REG_ORDER[i];
			cfg_data  <= REG_PLAN[row][i];
			do @(posedge clk); while (!cfg_ready);
			book.write_reg(REG_ORDER[i], REG_PLAN[row][i]);
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, drain all predicted results, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (book.due_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed frames for the current settings, plus noise and broken frames
	task automatic random_traffic(input int budget);
		logic [7:0] pkt [$];
		logic [7:0] len;
		logic [7:0] x;
		logic [7:0] d;
		int sent;
		int kind;
		int t;
		int lim;
		int n;
		sent = 0;
		while (sent < budget) begin
			pkt.delete();
			kind = $urandom_range(0, 9);
			lim  = book.type_limit();
			t    = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, 3);
			len  = {2'b00, book.size_of[t]};
			if (kind < 7) begin
				// Complete frame, occasionally with a corrupted checksum
				pkt.push_back(HDR_BYTE);
				pkt.push_back(8'(t));
				pkt.push_back(len);
				if (len >= 1 && len <= PAYLOAD_MAX) begin
					x = len;
					for (int i = 0; i < len; i++) begin
						d = 8'($urandom_range(0, 255));
						x = x ^ d;
						pkt.push_back(d);
					end
					if ($urandom_range(0, 4) == 0) x = x ^ (8'd1 << $urandom_range(0, 7));
					pkt.push_back(x);
				end
			end else if (kind == 7) begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
			end else if (kind == 8) begin
				pkt.push_back(HDR_BYTE);
				pkt.push_back(8'($urandom_range(0, 255)));
				pkt.push_back(8'($urandom_range(0, 255)));
			end else begin
				// Truncated frame: the next frame gets swallowed as payload
				pkt.push_back(HDR_BYTE);
				pkt.push_back(8'(t));
				pkt.push_back(len);
				n = (len >= 1 && len <= PAYLOAD_MAX) ? $urandom_range(0, len - 1) : 0;
				for (int i = 0; i < n; i++) pkt.push_back(8'($urandom_range(0, 255)));
			end
			foreach (pkt[k]) send_byte(pkt[k]);
			sent += pkt.size();
		end
	endtask

	// Output side: random stalls, one long hold-off to back up the input
	initial begin
		int gap;
		bit long_hold_done;
		result_t got;
		out_stall      = 1'b0;
		long_hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && results_seen >= 4) begin
				gap            = LONG_HOLD;
				long_hold_done = 1'b1;
			end else begin
				gap = pick_gap(rx_calm);
			end
			@(negedge clk);
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			got.pkt_type     = pkt_type;
			got.byte_index   = byte_index;
			got.data_byte    = data_byte;
			got.last         = last;
			got.frame_status = frame_status;
			book.check_delivery(got);
			results_seen++;
		end
	end

	// Main sequence
	initial begin
		book         = new();
		tx_calm      = 0;
		rx_calm      = 0;
		results_seen = 0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		rx_byte      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_NUM_TYPES;
		cfg_data     = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		foreach (OPENING[k]) send_byte(OPENING[k]);
		settle();

		for (int p = 0; p < 6; p++) begin
			program_regs(p);
			random_traffic(PHASE_BYTES[p]);
			settle();
		end

		if (book.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Hang guard
	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
